/* src/kps_pkg.sv */
// Shared constants, register codes and control types for the polled key scanner.
`default_nettype none
package kps_pkg;

    localparam int MAX_KEYS      = 32;
    localparam int INTERVAL_BITS = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W     = 6;
    localparam int CFG_DATA_W    = 32;

    localparam logic [KEY_CNT_W-1:0]     COUNT_LIMIT     = 6'd63;
    localparam logic [KEY_CNT_W-1:0]     RST_KEY_COUNT   = 6'd32;
    localparam logic [MAX_KEYS-1:0]      RST_POLARITY    = '1;
    localparam logic [INTERVAL_BITS-1:0] RST_POLL_IVL    = 16'd20;
    localparam logic [INTERVAL_BITS-1:0] RST_DEBOUNCE    = 16'd40;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_COUNT     = 2'd0,
        CFG_POLARITY_MASK = 2'd1,
        CFG_POLL_IVL      = 2'd2,
        CFG_DEBOUNCE_IVL  = 2'd3
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic tick_only;   // decrement the wait counter
        logic start_poll;  // capture levels and build change set
        logic emit;        // load one event into the output register
        logic finish;      // reload the wait counter
    } kps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic poll_due;    // wait counter reaches zero on this tick
        logic pending;     // changed keys remain to be reported
        logic slot_free;   // output register can take an event
    } kps_status_t;

    // mask of keys that are scanned for a given key count
    function automatic logic [MAX_KEYS-1:0] active_mask(input logic [KEY_CNT_W-1:0] kc);
        logic [KEY_CNT_W:0]  n;
        logic [MAX_KEYS-1:0] m;
        n = {1'b0, kc};
        if (kc == '0 || n > (KEY_CNT_W+1)'(MAX_KEYS))
        begin
            n = (KEY_CNT_W+1)'(MAX_KEYS);
        end
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            m[i] = ((KEY_CNT_W+1)'(i) < n);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* src/kps_in_if.sv */
// Input channel: one beat per tick with the raw key pin levels.
`default_nettype none
interface kps_in_if;
    logic                          valid;
    logic                          ready;
    logic [kps_pkg::MAX_KEYS-1:0]  key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface
`default_nettype wire

/* src/kps_out_if.sv */
// Output channel: one beat per key state change.
`default_nettype none
interface kps_out_if;
    logic                          valid;
    logic                          ready;
    logic [kps_pkg::KEY_IDX_W-1:0] key_index;
    logic                          key_pressed;
    logic                          last_event;

    modport source (output valid, output key_index, output key_pressed,
                    output last_event, input ready);
    modport sink   (input valid, input key_index, input key_pressed,
                    input last_event, output ready);
endinterface
`default_nettype wire

/* src/kps_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none
interface kps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     index;
    logic [kps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/kps_ctrl.sv */
// Scanner controller: sequences tick handling, change scan and counter reload.
`default_nettype none
module kps_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire kps_pkg::kps_status_t status,
    output kps_pkg::kps_cmd_t         cmd
);
    import kps_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.poll_due)
                    begin
                        cmd.start_poll = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.tick_only = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!status.pending)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* src/kps_dp.sv */
// Scanner datapath: config registers, key map, counters and event output register.
`default_nettype none
module kps_dp
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire kps_pkg::kps_cmd_t                cmd,
    output kps_pkg::kps_status_t                  status,
    input  wire logic [kps_pkg::MAX_KEYS-1:0]     key_levels,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [kps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [kps_pkg::KEY_IDX_W-1:0]         key_index,
    output logic                                  key_pressed,
    output logic                                  last_event
);
    import kps_pkg::*;

    logic [KEY_CNT_W-1:0]     key_count_reg;
    logic [MAX_KEYS-1:0]      polarity_reg;
    logic [INTERVAL_BITS-1:0] poll_ivl_reg;
    logic [INTERVAL_BITS-1:0] debounce_reg;

    logic [MAX_KEYS-1:0]      map_reg;
    logic [KEY_CNT_W-1:0]     count_reg;
    logic [INTERVAL_BITS-1:0] wait_reg;
    logic [MAX_KEYS-1:0]      press_reg;
    logic [MAX_KEYS-1:0]      change_reg;

    logic                     out_valid_reg;
    logic [KEY_IDX_W-1:0]     out_index_reg;
    logic                     out_pressed_reg;
    logic                     out_last_reg;

    logic [MAX_KEYS-1:0]      pressed_now;
    logic [MAX_KEYS-1:0]      low_bit;
    logic [MAX_KEYS-1:0]      change_rest;
    logic [KEY_IDX_W-1:0]     low_idx;
    logic                     low_pressed;

    // pressed state per key for the current beat
    assign pressed_now = key_levels ^ polarity_reg;

    // lowest changed key still to report
    assign low_bit     = change_reg & (~change_reg + MAX_KEYS'(1));
    assign change_rest = change_reg & ~low_bit;
    assign low_pressed = |(press_reg & low_bit);

    always_comb
    begin
        low_idx = '0;
        for (int i = MAX_KEYS - 1; i >= 0; i--)
        begin
            if (change_reg[i])
            begin
                low_idx = KEY_IDX_W'(i);
            end
        end
    end

    // status to controller
    assign status.poll_due  = (wait_reg <= INTERVAL_BITS'(1));
    assign status.pending   = |change_reg;
    assign status.slot_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= RST_KEY_COUNT;
            polarity_reg  <= RST_POLARITY;
            poll_ivl_reg  <= RST_POLL_IVL;
            debounce_reg  <= RST_DEBOUNCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_KEY_COUNT:     key_count_reg <= cfg_data[KEY_CNT_W-1:0];
                CFG_POLARITY_MASK: polarity_reg  <= cfg_data[MAX_KEYS-1:0];
                CFG_POLL_IVL:      poll_ivl_reg  <= cfg_data[INTERVAL_BITS-1:0];
                CFG_DEBOUNCE_IVL:  debounce_reg  <= cfg_data[INTERVAL_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // wait counter, key map, pressed count and change set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg   <= '0;
            map_reg    <= '0;
            count_reg  <= '0;
            change_reg <= '0;
            press_reg  <= '0;
        end
        else
        begin
            if (cmd.tick_only)
            begin
                wait_reg <= wait_reg - INTERVAL_BITS'(1);
            end
            if (cmd.start_poll)
            begin
                wait_reg   <= '0;
                press_reg  <= pressed_now;
                change_reg <= (pressed_now ^ map_reg) & active_mask(key_count_reg);
            end
            if (cmd.emit)
            begin
                change_reg <= change_rest;
                if (low_pressed)
                begin
                    map_reg <= map_reg | low_bit;
                    if (count_reg != COUNT_LIMIT)
                    begin
                        count_reg <= count_reg + KEY_CNT_W'(1);
                    end
                end
                else
                begin
                    map_reg <= map_reg & ~low_bit;
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - KEY_CNT_W'(1);
                    end
                end
            end
            if (cmd.finish)
            begin
                wait_reg <= (count_reg != '0) ? debounce_reg : poll_ivl_reg;
            end
        end
    end

    // event output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_index_reg   <= low_idx;
            out_pressed_reg <= low_pressed;
            out_last_reg    <= (change_rest == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_index   = out_index_reg;
    assign key_pressed = out_pressed_reg;
    assign last_event  = out_last_reg;

endmodule
`default_nettype wire

/* src/gpio_key_poll_scanner_unit.sv */
// Top level of the polled key scanner: controller, datapath and channel wiring.
//
// Each beat on keys is one time tick with the raw levels of up to 32 key pins.
// A tick that does not poll only decrements the wait counter. A polling tick
// reports each changed key, one beat per cycle on events in ascending key
// index with last_event on the final change; the single event output register
// sets that pace, and a stalled events channel stretches it. keys accepts the
// next tick only after the scan of the current one is done. Configuration
// writes are taken every cycle and belong between polls.
`default_nettype none
module gpio_key_poll_scanner_unit
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kps_in_if.sink     keys,
    kps_out_if.source  events,
    kps_cfg_if.sink    cfg
);
    import kps_pkg::*;

    kps_cmd_t    cmd;
    kps_status_t status;
    logic        in_ready;

    assign keys.ready = in_ready;
    assign cfg.ready  = 1'b1;

    kps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kps_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .key_levels  (keys.key_levels),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (events.valid),
        .out_ready   (events.ready),
        .key_index   (events.key_index),
        .key_pressed (events.key_pressed),
        .last_event  (events.last_event)
    );

endmodule
`default_nettype wire
